>>> hdl/assert_macros.svh
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication with asynchronous reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// plain invariant sampled at every edge
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`endif

>>> hdl/hsms_pkg.sv
// ----------------------------------------------------------------------------
// hsms_pkg
// shared constants and types for the motion step pipeline
// ----------------------------------------------------------------------------
package hsms_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam logic signed [33:0] CordicGainInv = 34'sh026DD3B6A;

  // arctangent table, Q0.32 turns
  function automatic logic signed [33:0] atan_turn(input int unsigned idx);
    logic signed [33:0] v;
    begin
      v = '0;
      case (idx)
        0:  v = 34'sh020000000;
        1:  v = 34'sh012E4051E;
        2:  v = 34'sh009FB385B;
        3:  v = 34'sh0051111D4;
        4:  v = 34'sh0028B0D43;
        5:  v = 34'sh00145D7E1;
        6:  v = 34'sh000A2F61E;
        7:  v = 34'sh000517C55;
        8:  v = 34'sh00028BE53;
        9:  v = 34'sh000145F2F;
        10: v = 34'sh0000A2F98;
        11: v = 34'sh0000517CC;
        12: v = 34'sh000028BE6;
        13: v = 34'sh0000145F3;
        14: v = 34'sh000000A2F9;
        15: v = 34'sh00000517C;
        16: v = 34'sh0000028BE;
        17: v = 34'sh00000145F;
        18: v = 34'sh000000A2F;
        19: v = 34'sh000000517;
        20: v = 34'sh00000028B;
        21: v = 34'sh000000145;
        22: v = 34'sh0000000A2;
        23: v = 34'sh000000051;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // register indexes
  localparam logic [1:0] RegMaxLin   = 2'd0;
  localparam logic [1:0] RegMaxAng   = 2'd1;
  localparam logic [1:0] RegFriction = 2'd2;

  localparam logic [30:0] MaxLinReset = 31'd655360;
  localparam logic [30:0] MaxAngReset = 31'd65536;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    begin
      if (v > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
      else if (v < -64'sh0000000080000000) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] lin_speed;
    logic signed [31:0] lin_sp2;
    logic signed [31:0] ang_sp2;
    logic [15:0]        time_step;
  } hsms_side_t;

endpackage

>>> hdl/hsms_cordic.sv
// ----------------------------------------------------------------------------
// hsms_cordic
// pipelined rotation cordic, a few iterations per stage, with side payload
// ----------------------------------------------------------------------------
module hsms_cordic #(
  parameter int unsigned PerStage = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [31:0]               angle_i,
  input  hsms_pkg::hsms_side_t      side_i,
  output logic                      valid_o,
  output logic signed [33:0]        cos_o,
  output logic signed [33:0]        sin_o,
  output hsms_pkg::hsms_side_t      side_o
);
  import hsms_pkg::*;

  localparam int unsigned NStg = CordicSteps / PerStage;

  logic                valid_q [NStg+1];
  logic signed [33:0]  x_q     [NStg+1];
  logic signed [33:0]  y_q     [NStg+1];
  logic signed [33:0]  z_q     [NStg+1];
  logic [1:0]          quad_q  [NStg+1];
  hsms_side_t          side_q  [NStg+1];

  always_comb begin
    valid_q[0] = valid_i;
    x_q[0]     = CordicGainInv;
    y_q[0]     = '0;
    z_q[0]     = {4'b0, angle_i[29:0]};
    quad_q[0]  = angle_i[31:30];
    side_q[0]  = side_i;
  end

  for (genvar s = 0; s < NStg; s++) begin : g_stg
    logic signed [33:0] x_d, y_d, z_d;
    always_comb begin
      logic signed [33:0] dx, dy;
      x_d = x_q[s];
      y_d = y_q[s];
      z_d = z_q[s];
      for (int k = 0; k < PerStage; k++) begin
        dx = y_d >>> (s * PerStage + k);
        dy = x_d >>> (s * PerStage + k);
        if (!z_d[33]) begin
          x_d = x_d - dx; y_d = y_d + dy; z_d = z_d - atan_turn(s * PerStage + k);
        end else begin
          x_d = x_d + dx; y_d = y_d - dy; z_d = z_d + atan_turn(s * PerStage + k);
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else begin
        valid_q[s+1] <= valid_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      x_q[s+1]    <= x_d;
      y_q[s+1]    <= y_d;
      z_q[s+1]    <= z_d;
      quad_q[s+1] <= quad_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  always_comb begin
    unique case (quad_q[NStg])
      2'd0: begin cos_o = x_q[NStg];  sin_o = y_q[NStg];  end
      2'd1: begin cos_o = -y_q[NStg]; sin_o = x_q[NStg];  end
      2'd2: begin cos_o = -x_q[NStg]; sin_o = -y_q[NStg]; end
      default: begin cos_o = y_q[NStg]; sin_o = -x_q[NStg]; end
    endcase
  end

  assign valid_o = valid_q[NStg];
  assign side_o  = side_q[NStg];
endmodule

>>> hdl/hsms_speed.sv
// ----------------------------------------------------------------------------
// hsms_speed
// speed update over four stages: products, add and clamp, dt times magnitude,
// friction
// ----------------------------------------------------------------------------
module hsms_speed (
  input  logic               clk_i,
  input  logic signed [31:0] lin_speed_i,
  input  logic signed [31:0] ang_speed_i,
  input  logic signed [31:0] lin_accel_i,
  input  logic signed [31:0] ang_accel_i,
  input  logic [15:0]        time_step_i,
  input  logic [30:0]        max_lin_i,
  input  logic [30:0]        max_ang_i,
  input  logic [23:0]        friction_i,
  output logic signed [31:0] lin_speed_o,
  output logic signed [31:0] ang_speed_o
);
  import hsms_pkg::*;

  logic signed [48:0] la_q, aa_q;
  logic signed [31:0] vl_q, va_q;
  logic [15:0]        dt_q;
  logic signed [32:0] cl_q, ca_q;
  logic [15:0]        dt2_q;
  logic signed [32:0] cl2_q;
  logic [48:0]        dm_q;
  logic signed [41:0] out_l_q;
  logic signed [31:0] out_a_q;
  logic signed [31:0] out_a2_q;

  function automatic logic signed [32:0] clamp(input logic signed [33:0] v,
                                               input logic [30:0] lim);
    logic signed [33:0] l;
    begin
      l = {3'b0, lim};
      if (v > l) return l[32:0];
      if (v < -l) return 33'(-l);
      return v[32:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    // stage a: products
    la_q <= lin_accel_i * $signed({1'b0, time_step_i});
    aa_q <= ang_accel_i * $signed({1'b0, time_step_i});
    vl_q <= lin_speed_i;
    va_q <= ang_speed_i;
    dt_q <= time_step_i;
    // stage b: add and clamp
    cl_q  <= clamp(34'(vl_q) + 34'(la_q >>> 16), max_lin_i);
    ca_q  <= clamp(34'(va_q) + 34'(aa_q >>> 16), max_ang_i);
    dt2_q <= dt_q;
    // stage c: dt times magnitude
    cl2_q <= cl_q;
    dm_q  <= 49'(dt2_q) * 49'(cl_q[32] ? -cl_q : cl_q);
    out_a_q <= ca_q[31:0];
    // stage d: friction
    out_l_q <= (cl2_q > 0)
      ? 42'(cl2_q) - 42'((dm_q[48:16] * 57'(friction_i)) >> 16)
      : 42'(cl2_q) + 42'((dm_q[48:16] * 57'(friction_i)) >> 16);
    out_a2_q <= out_a_q;
  end

  assign lin_speed_o = sat32(64'(out_l_q));
  assign ang_speed_o = out_a2_q;
endmodule

>>> hdl/heading_speed_motion_step_unit.sv
// ----------------------------------------------------------------------------
// heading_speed_motion_step_unit
// one euler step of a heading plus forward speed body in Q16.16
// ----------------------------------------------------------------------------
// usage: raise start with one body word on the input ports; a word is
// taken at every edge where start is high and busy low. busy stays
// low, so a new word can enter every cycle (one word per cycle).
// results leave on the output ports in order, with done_o high for one cycle.
// the pipeline is the heading multiply, the six-stage cordic and the
// velocity product, velocity saturate with position product and position
// add after it; the speed path runs alongside and ends on the same edge.
// configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// reset clears the valid pipeline and loads the default speed limits.
// the receiver cannot stall, so there is no back-pressure.
// ----------------------------------------------------------------------------
module heading_speed_motion_step_unit #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [30:0]            cfg_data_i,
  input  logic signed [31:0]     pos_x_i,
  input  logic signed [31:0]     pos_z_i,
  input  logic [ANGLE_BITS-1:0]  heading_i,
  input  logic signed [31:0]     lin_speed_i,
  input  logic signed [31:0]     ang_speed_i,
  input  logic signed [31:0]     lin_accel_i,
  input  logic signed [31:0]     ang_accel_i,
  input  logic [15:0]            time_step_i,
  output logic                   done_o,
  output logic signed [31:0]     new_pos_x_o,
  output logic signed [31:0]     new_pos_z_o,
  output logic [ANGLE_BITS-1:0]  new_heading_o,
  output logic signed [31:0]     new_lin_speed_o,
  output logic signed [31:0]     new_ang_speed_o,
  output logic signed [31:0]     vel_x_o,
  output logic signed [31:0]     vel_z_o
);
  import hsms_pkg::*;

  localparam int unsigned Shift = 32 - ANGLE_BITS;

  logic [30:0] max_lin_q, max_ang_q;
  logic [23:0] fric_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_q <= MaxLinReset;
      max_ang_q <= MaxAngReset;
      fric_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxLin:   max_lin_q <= cfg_data_i;
        RegMaxAng:   max_ang_q <= cfg_data_i;
        RegFriction: fric_q    <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic acc;
  assign acc = start & ~busy;

  // stage 1: heading product
  logic               v1_q;
  logic signed [48:0] hp_q;
  logic [ANGLE_BITS-1:0] hd1_q;
  hsms_side_t         s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    hp_q  <= ang_speed_i * $signed({1'b0, time_step_i});
    hd1_q <= heading_i;
    s1_q  <= '{pos_x: pos_x_i, pos_z: pos_z_i, lin_speed: lin_speed_i,
               lin_sp2: '0, ang_sp2: '0, time_step: time_step_i};
  end

  logic [ANGLE_BITS-1:0] nh;
  logic [31:0] hp_lo;
  assign hp_lo = hp_q[31:0];
  assign nh = hd1_q + hp_lo[Shift +: ANGLE_BITS];

  // heading rides alongside the cordic via a delay line
  logic vc;
  logic signed [33:0] cs, sn;
  hsms_side_t sc;

  hsms_cordic u_cordic (
    .clk_i, .rst_ni, .valid_i(v1_q), .angle_i({nh, {Shift{1'b0}}}),
    .side_i(s1_q), .valid_o(vc), .cos_o(cs), .sin_o(sn), .side_o(sc)
  );

  localparam int unsigned CDly = CordicSteps / 4;
  logic [ANGLE_BITS-1:0] hdl_q [CDly+3];
  always_ff @(posedge clk_i) begin
    hdl_q[0] <= nh;
    for (int i = 1; i < CDly + 3; i++) hdl_q[i] <= hdl_q[i-1];
  end

  // speed path, aligned to the end of the pipe
  logic signed [31:0] ls_a [CDly];
  logic signed [31:0] as_a [CDly];
  logic signed [31:0] la_a [CDly];
  logic signed [31:0] aa_a [CDly];
  logic [15:0]        dt_a [CDly];
  logic signed [31:0] ang_in_q;
  always_ff @(posedge clk_i) begin
    ang_in_q <= ang_speed_i;
    ls_a[0] <= s1_q.lin_speed; as_a[0] <= ang_in_q;
    la_a[0] <= lin_accel_i;    aa_a[0] <= ang_accel_i;
    dt_a[0] <= s1_q.time_step;
    for (int i = 1; i < CDly; i++) begin
      ls_a[i] <= ls_a[i-1]; as_a[i] <= as_a[i-1];
      la_a[i] <= la_a[i-1]; aa_a[i] <= aa_a[i-1]; dt_a[i] <= dt_a[i-1];
    end
  end

  // registered copies of the accel inputs; only the unused sink reads them
  logic signed [31:0] la_d_q, aa_d_q;
  always_ff @(posedge clk_i) begin
    la_d_q <= lin_accel_i;
    aa_d_q <= ang_accel_i;
  end

  hsms_speed u_speed (
    .clk_i,
    .lin_speed_i(ls_a[CDly-2]), .ang_speed_i(as_a[CDly-2]),
    .lin_accel_i(la_a[CDly-1]), .ang_accel_i(aa_a[CDly-1]),
    .time_step_i(dt_a[CDly-2]),
    .max_lin_i(max_lin_q), .max_ang_i(max_ang_q), .friction_i(fric_q),
    .lin_speed_o(new_lin_speed_o), .ang_speed_o(new_ang_speed_o)
  );

  // velocity stage
  logic               v2_q, v3_q, v4_q;
  logic signed [65:0] px_q, pz_q;
  hsms_side_t         s2_q, s3_q;
  logic signed [31:0] vx_q, vz_q;
  logic signed [48:0] dx_q, dz_q;
  logic signed [31:0] ox_q, oz_q, vx2_q, vz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else begin
      v2_q <= vc; v3_q <= v2_q; v4_q <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    px_q  <= sc.lin_speed * cs;
    pz_q  <= sc.lin_speed * sn;
    s2_q  <= sc;
    vx_q  <= sat32(64'(px_q >>> 30));
    vz_q  <= sat32(64'(pz_q >>> 30));
    s3_q  <= s2_q;
    dx_q  <= sat32(64'(px_q >>> 30)) * $signed({1'b0, s2_q.time_step});
    dz_q  <= sat32(64'(pz_q >>> 30)) * $signed({1'b0, s2_q.time_step});
    ox_q  <= sat32(64'(s3_q.pos_x) + 64'(dx_q >>> 16));
    oz_q  <= sat32(64'(s3_q.pos_z) + 64'(dz_q >>> 16));
    vx2_q <= vx_q;
    vz2_q <= vz_q;
  end

  assign done_o          = v4_q;
  assign new_pos_x_o     = ox_q;
  assign new_pos_z_o     = oz_q;
  assign new_heading_o   = hdl_q[CDly+2];
  assign vel_x_o         = vx2_q;
  assign vel_z_o         = vz2_q;

  logic unused;
  assign unused = ^{la_d_q, aa_d_q, as_a[CDly-1], ls_a[CDly-1],
                    dt_a[CDly-1], hp_q[48:32], s3_q.lin_sp2};
endmodule

>>> hdl/hsms_checker.sv
// ----------------------------------------------------------------------------
// hsms_checker
// port level checks for the motion step unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hsms_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);
  `ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy)
  `ASSERT_IMPL(a_no_early_done, clk_i, rst_ni, $past(!rst_ni), !done_o)
  `ASSERT_IMPL(a_done_known, clk_i, rst_ni, 1'b1, !$isunknown(done_o))
  `ASSERT_ALWAYS(a_start_known, clk_i, rst_ni, !$isunknown(start))
endmodule

bind heading_speed_motion_step_unit hsms_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o
);
